[design/dtf_pkg.sv]
// Shared types, constants and binary32 arithmetic for the decimal text parser.
package dtf_pkg;

	typedef enum logic [3:0] {
		PH_DONE = 4'b0001,
		PH_LEAD = 4'b0010,
		PH_INT  = 4'b0100,
		PH_FRAC = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [31:0] accum;
		logic [31:0] scale;
		logic        negative;
		logic        seen_digit;
	} fp_state_t;

	localparam logic [31:0] FP_ZERO     = 32'h0000_0000;
	localparam logic [31:0] FP_TENTH    = 32'h3DCC_CCCD;
	localparam logic [31:0] FP_INF      = 32'h7F80_0000;
	localparam logic [23:0] TENTH_MANT  = 24'hCC_CCCD;
	localparam int          TENTH_EXP   = 123;
	localparam logic [7:0]  CH_ZERO     = 8'h30;
	localparam logic [7:0]  CH_NINE     = 8'h39;
	localparam logic [7:0]  CH_SPACE    = 8'h20;
	localparam logic [7:0]  CH_TAB      = 8'h09;
	localparam logic [7:0]  CH_POINT    = 8'h2E;
	localparam logic [7:0]  CH_MINUS    = 8'h2D;
	localparam logic [7:0]  CH_PLUS     = 8'h2B;
	localparam int          OUT_BITS    = 16;

	// value = m * 2^e, rounded to nearest even binary32
	function automatic logic [31:0] round_pack(input logic [50:0] m, input int e);
		int k;
		int sh;
		int s;
		int be;
		logic [63:0] mw;
		logic [63:0] q;
		logic [63:0] r;
		logic [63:0] h;
		logic [24:0] mant;
		logic up;
		k = 0;
		for (int i = 0; i < 51; i++) begin
			if (m[i]) k = i;
		end
		sh = k - 23;
		if (-149 - e > sh) sh = -149 - e;
		mw = {13'b0, m};
		if (sh > 0) begin
			s = (sh > 63) ? 63 : sh;
			q = mw >> s;
			r = mw & ((64'd1 << s) - 64'd1);
			h = 64'd1 << (s - 1);
			up = (r > h) || ((r == h) && q[0]);
			mant = q[24:0] + {24'b0, up};
		end else begin
			q = mw << (-sh);
			mant = q[24:0];
		end
		be = e + sh + 150;
		if (mant[24]) begin
			mant = mant >> 1;
			be = be + 1;
		end
		if (!mant[23]) return {9'b0, mant[22:0]};
		if (be >= 255) return FP_INF;
		return {1'b0, be[7:0], mant[22:0]};
	endfunction

	function automatic logic [23:0] mant_of(input logic [31:0] a);
		return (a[30:23] == 8'd0) ? {1'b0, a[22:0]} : {1'b1, a[22:0]};
	endfunction

	function automatic int exp_of(input logic [31:0] a);
		return (a[30:23] == 8'd0) ? 1 : int'(a[30:23]);
	endfunction

	// sum of two non-negative values
	function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] x;
		logic [31:0] y;
		int d;
		logic [63:0] xw;
		logic [63:0] yw;
		logic [63:0] part;
		logic [63:0] m;
		logic st;
		if (a[30:23] == 8'hFF || b[30:23] == 8'hFF) return FP_INF;
		if (exp_of(b) > exp_of(a)) begin
			x = b;
			y = a;
		end else begin
			x = a;
			y = b;
		end
		d = exp_of(x) - exp_of(y);
		xw = {14'b0, mant_of(x), 26'b0};
		yw = {14'b0, mant_of(y), 26'b0};
		if (d >= 63) begin
			part = 64'd0;
			st = |mant_of(y);
		end else begin
			part = yw >> d;
			st = |(yw & ((64'd1 << d) - 64'd1));
		end
		m = xw + part;
		m[0] = m[0] | st;
		return round_pack(m[50:0], exp_of(x) - 176);
	endfunction

	function automatic logic [31:0] mul_ten(input logic [31:0] a);
		logic [27:0] p;
		if (a[30:23] == 8'hFF) return a;
		p = {4'b0, mant_of(a)} * 28'd10;
		return round_pack({23'b0, p}, exp_of(a) - 150);
	endfunction

	function automatic logic [31:0] digit_times(input logic [3:0] d, input logic [31:0] s);
		logic [27:0] p;
		p = {4'b0, mant_of(s)} * {24'b0, d};
		return round_pack({23'b0, p}, exp_of(s) - 150);
	endfunction

	function automatic logic [31:0] mul_tenth(input logic [31:0] s);
		logic [47:0] p;
		p = {24'b0, mant_of(s)} * {24'b0, TENTH_MANT};
		return round_pack({3'b0, p}, exp_of(s) + TENTH_EXP - 300);
	endfunction

	function automatic logic [31:0] digit_float(input logic [3:0] d);
		return round_pack({47'b0, d}, 0);
	endfunction

endpackage

[design/dtf_step.sv]
// One parse step: next parse state and the result for one character.
module dtf_step #(
	parameter int COUNT_BITS = 16
) (
	input  logic [7:0]             ch,
	input  logic                   start_req,
	input  dtf_pkg::phase_t        phase,
	input  dtf_pkg::fp_state_t     st,
	input  logic [COUNT_BITS-1:0]  count,
	output dtf_pkg::phase_t        phase_nx,
	output dtf_pkg::fp_state_t     st_nx,
	output logic [COUNT_BITS-1:0]  count_nx,
	output logic                   emit,
	output logic [31:0]            value_bits,
	output logic [15:0]            consumed,
	output logic                   got_digit
);
	import dtf_pkg::*;

	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	logic                      is_digit;
	logic [3:0]                dig;
	logic                      bump;
	logic [COUNT_BITS+15:0]    cnt_ext;
	logic [31:0]               int_val;
	logic [31:0]               frac_val;
	logic [31:0]               scale_nx;

	assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
	assign dig      = 4'(ch - CH_ZERO);
	assign int_val  = fadd(mul_ten(start_req ? FP_ZERO : st.accum), digit_float(dig));
	assign frac_val = fadd(st.accum, digit_times(dig, st.scale));
	assign scale_nx = mul_tenth(st.scale);

	always_comb begin
		phase_nx = phase;
		st_nx    = st;
		count_nx = count;
		emit     = 1'b0;
		bump     = 1'b0;
		if (start_req) begin
			st_nx    = '{accum: FP_ZERO, scale: FP_TENTH, negative: 1'b0, seen_digit: 1'b0};
			count_nx = '0;
			phase_nx = PH_LEAD;
		end
		if (phase_nx == PH_LEAD) begin
			if (ch == CH_SPACE || ch == CH_TAB) begin
				bump = 1'b1;
			end else if (ch == CH_MINUS || ch == CH_PLUS) begin
				st_nx.negative = (ch == CH_MINUS);
				bump     = 1'b1;
				phase_nx = PH_INT;
			end else begin
				phase_nx = PH_INT;
				if (is_digit) begin
					st_nx.accum      = int_val;
					st_nx.seen_digit = 1'b1;
					bump             = 1'b1;
				end else if (ch == CH_POINT) begin
					bump     = 1'b1;
					phase_nx = PH_FRAC;
				end else begin
					emit = 1'b1;
				end
			end
		end else begin
			case (phase_nx)
				PH_INT: begin
					if (is_digit) begin
						st_nx.accum      = int_val;
						st_nx.seen_digit = 1'b1;
						bump             = 1'b1;
					end else if (ch == CH_POINT) begin
						bump     = 1'b1;
						phase_nx = PH_FRAC;
					end else begin
						emit = 1'b1;
					end
				end
				PH_FRAC: begin
					if (is_digit) begin
						st_nx.accum      = frac_val;
						st_nx.scale      = scale_nx;
						st_nx.seen_digit = 1'b1;
						bump             = 1'b1;
					end else begin
						emit = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
		if (bump && count_nx != CNT_MAX) count_nx = count_nx + 1'b1;
		if (emit) phase_nx = PH_DONE;
	end

	assign cnt_ext    = {16'b0, count_nx};
	assign value_bits = {st_nx.accum[31] ^ st_nx.negative, st_nx.accum[30:0]};
	assign got_digit  = st_nx.seen_digit;
	assign consumed   = !st_nx.seen_digit ? '0 :
		(cnt_ext > {{COUNT_BITS{1'b0}}, {OUT_BITS{1'b1}}}) ? {OUT_BITS{1'b1}} : cnt_ext[15:0];

endmodule

[design/decimal_text_to_float_parser_top.sv]
// Top level of the decimal text to binary32 parser.
// Takes one character per transfer and can take one every cycle while in_stall
// is low. A character enters an input register and is then parsed against the
// stored state; if it ends the number, the value, count and digit flag are
// written to the output register once that register is free, so a result is
// offered once its terminator has passed the input and output registers.
// The float multiply and add of one digit are combinational in the parse step.
// in_stall rises only when a terminator waits behind an unread result.
module decimal_text_to_float_parser_top #(
	parameter int COUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  ch,
	input  logic        start_req,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] value_bits,
	output logic [15:0] consumed,
	output logic        got_digit
);
	import dtf_pkg::*;

	logic                  valid_s1;
	logic [7:0]            ch_s1;
	logic                  start_s1;
	phase_t                phase_q;
	fp_state_t             st_q;
	logic [COUNT_BITS-1:0] count_q;
	phase_t                phase_nx;
	fp_state_t             st_nx;
	logic [COUNT_BITS-1:0] count_nx;
	logic                  emit;
	logic [31:0]           val_nx;
	logic [15:0]           cons_nx;
	logic                  got_nx;
	logic                  out_free;
	logic                  advance;

	dtf_step #(.COUNT_BITS(COUNT_BITS)) u_step (
		.ch        (ch_s1),
		.start_req (start_s1),
		.phase     (phase_q),
		.st        (st_q),
		.count     (count_q),
		.phase_nx  (phase_nx),
		.st_nx     (st_nx),
		.count_nx  (count_nx),
		.emit      (emit),
		.value_bits(val_nx),
		.consumed  (cons_nx),
		.got_digit (got_nx)
	);

	assign out_free = !out_valid || !out_stall;
	assign advance  = valid_s1 && (!emit || out_free);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			ch_s1    <= ch;
			start_s1 <= start_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DONE;
			st_q    <= '{accum: FP_ZERO, scale: FP_TENTH, negative: 1'b0, seen_digit: 1'b0};
			count_q <= '0;
		end else if (advance) begin
			phase_q <= phase_nx;
			st_q    <= st_nx;
			count_q <= count_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance && emit) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			value_bits <= val_nx;
			consumed   <= cons_nx;
			got_digit  <= got_nx;
		end
	end

endmodule
